[src/rsi_pkg.sv]
// Shared constants for the ray-sphere intersection unit.
`default_nettype none

package rsi_pkg;

    // Direction words are signed Q1.14.
    localparam int DIR_WIDTH = 16;
    localparam int DIR_FRAC  = 14;

    // Register word index on the configuration port.
    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } reg_index_t;

    // Radius after reset: 1.0 in Q12.12.
    localparam int RADIUS_RESET = 4096;

endpackage

`default_nettype wire

[src/ray_sphere_intersect_unit.sv]
// Pipelined ray-sphere intersection unit with APB configuration registers.
//
// Channel   Signals                                   Direction
// command   start, busy, origin_*, dir_*              in (busy is out, always low)
// result    result_valid, hit, distance               out, one cycle per word
// config    psel, penable, pwrite, paddr, pwdata,     APB slave
//           prdata, pready
//
// One word enters per cycle. Each result passes after its command through five
// arithmetic stages, one square-root stage per root bit (COORD_WIDTH + 6 of
// them) and the output register. The square-root chain sets the latency.
// Reset clears the valid bits and loads the register reset values. Nothing
// stalls: the receiver takes every result word.
`default_nettype none

module ray_sphere_intersect_unit #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Command channel
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [COORD_WIDTH-1:0]        origin_x,
    input  wire logic signed [COORD_WIDTH-1:0]        origin_y,
    input  wire logic signed [COORD_WIDTH-1:0]        origin_z,
    input  wire logic signed [rsi_pkg::DIR_WIDTH-1:0] dir_x,
    input  wire logic signed [rsi_pkg::DIR_WIDTH-1:0] dir_y,
    input  wire logic signed [rsi_pkg::DIR_WIDTH-1:0] dir_z,
    // Result channel
    output logic                                      result_valid,
    output logic                                      hit,
    output logic signed [COORD_WIDTH-1:0]             distance,
    // Configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [3:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = rsi_pkg::DIR_WIDTH;
    localparam int RB = W + 6;          // root bits
    localparam int NB = 2 * RB;         // radicand bits

    // Configuration registers.
    logic signed [W-1:0] cx_reg, cy_reg, cz_reg;
    logic [W-2:0]        radius_reg;
    logic                wr_en;
    rsi_pkg::reg_index_t wr_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = rsi_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            radius_reg <= (W-1)'(rsi_pkg::RADIUS_RESET);
        end
        else if (wr_en)
        begin
            case (wr_idx)
                rsi_pkg::REG_CENTER_X: cx_reg     <= pwdata[W-1:0];
                rsi_pkg::REG_CENTER_Y: cy_reg     <= pwdata[W-1:0];
                rsi_pkg::REG_CENTER_Z: cz_reg     <= pwdata[W-1:0];
                rsi_pkg::REG_RADIUS:   radius_reg <= pwdata[W-2:0];
                default:               cx_reg     <= cx_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (wr_idx)
            rsi_pkg::REG_CENTER_X: prdata = 32'(cx_reg);
            rsi_pkg::REG_CENTER_Y: prdata = 32'(cy_reg);
            rsi_pkg::REG_CENTER_Z: prdata = 32'(cz_reg);
            rsi_pkg::REG_RADIUS:   prdata = 32'(radius_reg);
            default:               prdata = '0;
        endcase
    end

    // Stage 1: offset from origin to center.
    logic                s1_valid_reg;
    logic signed [W:0]   rox_reg, roy_reg, roz_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        rox_reg <= (W+1)'(cx_reg) - (W+1)'(origin_x);
        roy_reg <= (W+1)'(cy_reg) - (W+1)'(origin_y);
        roz_reg <= (W+1)'(cz_reg) - (W+1)'(origin_z);
        dx_reg  <= dir_x;
        dy_reg  <= dir_y;
        dz_reg  <= dir_z;
    end

    // Stage 2: dot product terms, squared offsets and squared radius.
    logic                      s2_valid_reg;
    logic signed [W+DW:0]      px_reg, py_reg, pz_reg;
    logic signed [2*W+1:0]     qx_reg, qy_reg, qz_reg;
    logic [2*W-3:0]            r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        px_reg <= rox_reg * dx_reg;
        py_reg <= roy_reg * dy_reg;
        pz_reg <= roz_reg * dz_reg;
        qx_reg <= rox_reg * rox_reg;
        qy_reg <= roy_reg * roy_reg;
        qz_reg <= roz_reg * roz_reg;
        r2_reg <= radius_reg * radius_reg;
    end

    // Stage 3: sums.
    logic                   s3_valid_reg;
    logic signed [W+18:0]   dot_reg;
    logic [2*W+3:0]         minus_reg;
    logic [2*W-3:0]         r2b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        dot_reg   <= (W+19)'(px_reg) + (W+19)'(py_reg) + (W+19)'(pz_reg);
        minus_reg <= (2*W+4)'($unsigned(qx_reg)) + (2*W+4)'($unsigned(qy_reg))
                   + (2*W+4)'($unsigned(qz_reg));
        r2b_reg   <= r2_reg;
    end

    // Stage 4: v is the dot product floored to Q17.12, then squared.
    logic               s4_valid_reg;
    logic [W+4:0]       v4_reg;
    logic               neg4_reg;
    logic [2*W+9:0]     vsq_reg;
    logic [2*W+3:0]     minus4_reg;
    logic [2*W-3:0]     r2c_reg;
    logic [W+4:0]       v_floor;

    assign v_floor = dot_reg[W+18:rsi_pkg::DIR_FRAC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        v4_reg     <= v_floor;
        neg4_reg   <= dot_reg[W+18];
        vsq_reg    <= v_floor * v_floor;
        minus4_reg <= minus_reg;
        r2c_reg    <= r2b_reg;
    end

    // Stage 5: discriminant and miss decision, feeding the root chain.
    logic [2*W+10:0] plus_sum;
    logic [NB-1:0]   disc_diff;

    assign plus_sum  = {1'b0, vsq_reg} + (2*W+11)'(r2c_reg);
    assign disc_diff = {1'b0, plus_sum} - NB'(minus4_reg);

    logic           sq_valid_reg [0:RB];
    logic           sq_miss_reg  [0:RB];
    logic [W+4:0]   sq_v_reg     [0:RB];
    logic [NB-1:0]  sq_n_reg     [0:RB];
    logic [RB+1:0]  sq_rem_reg   [0:RB];
    logic [RB-1:0]  sq_root_reg  [0:RB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else
            sq_valid_reg[0] <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        sq_miss_reg[0] <= neg4_reg || disc_diff[NB-1];
        sq_v_reg[0]    <= v4_reg;
        sq_n_reg[0]    <= disc_diff;
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
    end

    // Square-root chain: one root bit per stage, restoring digit method.
    for (genvar i = 0; i < RB; i++)
    begin : g_sqrt
        logic [RB+1:0] rem_sh;
        logic [RB+1:0] trial;
        logic          ge;

        assign rem_sh = {sq_rem_reg[i][RB-1:0], sq_n_reg[i][NB-1:NB-2]};
        assign trial  = {sq_root_reg[i], 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[i+1] <= 1'b0;
            else
                sq_valid_reg[i+1] <= sq_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            sq_miss_reg[i+1] <= sq_miss_reg[i];
            sq_v_reg[i+1]    <= sq_v_reg[i];
            sq_n_reg[i+1]    <= {sq_n_reg[i][NB-3:0], 2'b00};
            sq_rem_reg[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
            sq_root_reg[i+1] <= {sq_root_reg[i][RB-2:0], ge};
        end
    end

    // Output: near distance, saturated; zero on a miss.
    logic signed [W+6:0] d_full;
    logic [7:0]          d_top;
    logic [W-1:0]        d_sat;

    assign d_full = {2'b00, sq_v_reg[RB]} - {1'b0, sq_root_reg[RB]};
    assign d_top  = d_full[W+6:W-1];
    assign d_sat  = ((d_top == 8'h00) || (d_top == 8'hff)) ? d_full[W-1:0]
                  : {d_full[W+6], {(W-1){~d_full[W+6]}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= sq_valid_reg[RB];
    end

    always_ff @(posedge clk)
    begin
        hit      <= ~sq_miss_reg[RB];
        distance <= sq_miss_reg[RB] ? '0 : d_sat;
    end

endmodule

`default_nettype wire
